@@ sv/vertex_screen_projection_unit_macros.svh @@
// Assertion macros for the vertex screen projection unit.
// Used by vertex_screen_projection_unit.sv; expects i_clk and i_rst_n in scope.
`ifndef VERTEX_SCREEN_PROJECTION_UNIT_MACROS_SVH
`define VERTEX_SCREEN_PROJECTION_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define VSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define VSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/vsp_pkg.sv @@
// Shared constants and codes of the vertex screen projection unit.
// No dependencies; imported by vertex_screen_projection_unit.
package vsp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int KIND_W      = 2;
    localparam int IDX_W       = 4;
    localparam int CFG_W       = 14;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(768);

    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] ONE_Q  = VALUE_WIDTH'(1) <<< FRAC_BITS;
    localparam logic signed [VALUE_WIDTH-1:0] HALF_Q = VALUE_WIDTH'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_MV = 2'd0,
        KIND_LOAD_PJ = 2'd1,
        KIND_COMPOSE = 2'd2,
        KIND_PROJECT = 2'd3
    } t_kind;

    typedef enum logic [0:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

@@ sv/vertex_screen_projection_unit.sv @@
// Vertex screen projection unit: matrix stores, shared multiply-accumulate and divider.
// Depends on vsp_pkg and vertex_screen_projection_unit_macros.svh.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_kind i_coef_index i_coef_value i_point_*
//  out     | output    | o_out_valid / i_out_stall| o_visible o_screen_x o_screen_y o_depth_w
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index i_cfg_data
//
// A coefficient load writes the store directly; a compose runs 64 multiply-adds through
// the one shared multiplier and then drains; a projection runs 16 multiply-adds and,
// when visible, the divider and four scalar products, each followed by a drain.
// Reset is synchronous; the combined matrix reads as identity through per-entry valid bits,
// so no clearing pass is run. A result held by i_out_stall does not block further loads
// or composes; a projection finishing meanwhile waits for the output register.
`include "vertex_screen_projection_unit_macros.svh"

module vertex_screen_projection_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [vsp_pkg::KIND_W-1:0]             i_kind,
    input  logic [vsp_pkg::IDX_W-1:0]              i_coef_index,
    input  logic signed [vsp_pkg::VALUE_WIDTH-1:0] i_coef_value,
    input  logic signed [vsp_pkg::VALUE_WIDTH-1:0] i_point_x,
    input  logic signed [vsp_pkg::VALUE_WIDTH-1:0] i_point_y,
    input  logic signed [vsp_pkg::VALUE_WIDTH-1:0] i_point_z,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_visible,
    output logic signed [vsp_pkg::VALUE_WIDTH-1:0] o_screen_x,
    output logic signed [vsp_pkg::VALUE_WIDTH-1:0] o_screen_y,
    output logic signed [vsp_pkg::VALUE_WIDTH-1:0] o_depth_w,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic                                   i_cfg_index,
    input  logic [vsp_pkg::CFG_W-1:0]              i_cfg_data
);
    import vsp_pkg::*;

    localparam int VW     = VALUE_WIDTH;
    localparam int PRD_W  = 2 * VW;
    localparam int RND_W  = PRD_W - FRAC_BITS + 1;
    localparam int CLP_W  = (RND_W < 61) ? RND_W : 61;
    localparam int BIG_W  = (RND_W > 61) ? RND_W : 61;
    localparam int ACC_W  = CLP_W + 3;
    localparam int DIV_W  = ((2 * FRAC_BITS - 1 > VW - 2) ? 2 * FRAC_BITS - 1 : VW - 2) + 1;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CISSUE, S_PISSUE, S_WAIT, S_PCHK, S_DIV,
        S_XMUL, S_XSCL, S_YMUL, S_YSCL, S_FIN
    } t_state;

    typedef enum logic [1:0] { SRC_MP, SRC_CB, SRC_SC } t_src;
    typedef enum logic [1:0] { DST_COMB, DST_VREG, DST_SCAL } t_dst;

    typedef struct packed {
        logic       vld;
        logic       first;
        logic       last;
        logic       shift;
        t_src       src;
        t_dst       dst;
        logic [3:0] addr;
    } t_tag;

    function automatic logic signed [VW-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic signed [VW-1:0] r;
        if (v > ACC_W'(VMAX))      r = VMAX;
        else if (v < ACC_W'(VMIN)) r = VMIN;
        else                       r = VW'(v);
        return r;
    endfunction

    function automatic logic signed [VW-1:0] sat_one(input logic signed [VW:0] v);
        logic signed [VW-1:0] r;
        if (v > (VW+1)'(VMAX))      r = VMAX;
        else if (v < (VW+1)'(VMIN)) r = VMIN;
        else                        r = VW'(v);
        return r;
    endfunction

    // Control and datapath registers.
    t_state r_state, r_ret;
    logic [5:0] r_cnt;
    logic signed [VW-1:0] r_px, r_py, r_pz, r_sa, r_sb, r_rq, r_sx;
    logic r_vis;
    logic [DIV_W-1:0] r_dnum;
    logic [VW-1:0] r_drem, r_dw;
    logic [DCNT_W-1:0] r_dcnt;
    logic [CFG_W-1:0] r_width, r_height;

    // Stores.
    logic [VW-1:0] r_mp_mem [32];
    logic [VW-1:0] r_cb_mem [16];
    logic [15:0] r_cb_v;
    logic signed [VW-1:0] r_mpa, r_mpb, r_cbq;
    logic r_cbv_q, r_cbdiag;

    // Pipeline.
    t_tag r_t1, r_t2;
    logic [PRD_W-1:0] r_prod;
    logic r_neg;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [VW-1:0] r_vx, r_vy, r_vw, r_sres;

    t_tag iss;
    logic [4:0] mp_ra, mp_rb;
    logic [3:0] cb_ra;
    logic in_acc;
    logic signed [VW-1:0] u_val, a_op, b_op, cb_val, ma, mb;
    logic [PRD_W:0] prd_add;
    logic [BIG_W-1:0] big;
    logic [CLP_W-1:0] mag_q;
    logic signed [CLP_W:0] sp;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [VW-1:0] acc_sat;
    logic [VW-1:0] trial;
    logic dbit;
    logic pipe_busy;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign pipe_busy   = r_t1.vld || r_t2.vld;
    assign u_val       = sat_one((VW+1)'(r_sres) + (VW+1)'(HALF_Q));

    // Issue: one multiply-add per cycle during compose and projection loops.
    always_comb begin
        iss   = '0;
        mp_ra = {1'b0, r_cnt[5:4], r_cnt[1:0]};
        mp_rb = {1'b1, r_cnt[1:0], r_cnt[3:2]};
        cb_ra = {r_cnt[1:0], r_cnt[3:2]};
        iss.shift = 1'b1;
        iss.src   = SRC_SC;
        iss.dst   = DST_SCAL;
        iss.first = 1'b1;
        iss.last  = 1'b1;
        unique case (r_state)
            S_CISSUE: begin
                iss.vld   = 1'b1;
                iss.src   = SRC_MP;
                iss.dst   = DST_COMB;
                iss.first = (r_cnt[1:0] == 2'd0);
                iss.last  = (r_cnt[1:0] == 2'd3);
                iss.addr  = {r_cnt[5:4], r_cnt[3:2]};
            end
            S_PISSUE: begin
                iss.vld   = 1'b1;
                iss.src   = SRC_CB;
                iss.dst   = DST_VREG;
                iss.first = (r_cnt[1:0] == 2'd0);
                iss.last  = (r_cnt[1:0] == 2'd3);
                iss.addr  = {2'b00, r_cnt[3:2]};
            end
            S_XMUL, S_YMUL: begin
                iss.vld = 1'b1;
            end
            S_XSCL, S_YSCL: begin
                iss.vld   = 1'b1;
                iss.shift = 1'b0;
            end
            default: begin
                iss.vld = 1'b0;
            end
        endcase
    end

    // Divider step: restoring, one quotient bit per cycle.
    always_comb begin
        trial = {r_drem[VW-2:0], r_dnum[DIV_W-1]};
        dbit  = (trial >= r_dw);
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_cnt       <= '0;
            r_dcnt      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && r_state != S_FIN) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (in_acc) begin
                        r_px <= i_point_x;
                        r_py <= i_point_y;
                        r_pz <= i_point_z;
                        if (i_kind == KIND_COMPOSE)      r_state <= S_CISSUE;
                        else if (i_kind == KIND_PROJECT) r_state <= S_PISSUE;
                    end
                end
                S_CISSUE: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_WAIT;
                        r_ret   <= S_IDLE;
                    end
                end
                S_PISSUE: begin
                    unique case (r_cnt[1:0])
                        2'd0:    r_sb <= r_px;
                        2'd1:    r_sb <= r_py;
                        2'd2:    r_sb <= r_pz;
                        default: r_sb <= ONE_Q;
                    endcase
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt[3:0] == 4'd15) begin
                        r_state <= S_WAIT;
                        r_ret   <= S_PCHK;
                    end
                end
                S_WAIT: begin
                    if (!pipe_busy) r_state <= r_ret;
                end
                S_PCHK: begin
                    r_vis <= (r_vw > 0);
                    if (r_vw > 0) begin
                        r_dnum  <= (DIV_W'(1) << (2 * FRAC_BITS - 1))
                                   + DIV_W'($unsigned(r_vw) >> 1);
                        r_drem  <= '0;
                        r_dw    <= $unsigned(r_vw);
                        r_dcnt  <= DCNT_W'(DIV_W);
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    if (r_dcnt != '0) begin
                        r_drem <= dbit ? (trial - r_dw) : trial;
                        r_dnum <= {r_dnum[DIV_W-2:0], dbit};
                        r_dcnt <= r_dcnt - DCNT_W'(1);
                    end else begin
                        if (r_dnum > DIV_W'($unsigned(VMAX))) r_rq <= VMAX;
                        else                                  r_rq <= VW'(r_dnum);
                        r_state <= S_XMUL;
                    end
                end
                S_XMUL: begin
                    r_sa    <= r_vx;
                    r_sb    <= r_rq;
                    r_state <= S_WAIT;
                    r_ret   <= S_XSCL;
                end
                S_XSCL: begin
                    r_sa    <= u_val;
                    r_sb    <= VW'(r_width);
                    r_state <= S_WAIT;
                    r_ret   <= S_YMUL;
                end
                S_YMUL: begin
                    r_sx    <= r_sres;
                    r_sa    <= r_vy;
                    r_sb    <= r_rq;
                    r_state <= S_WAIT;
                    r_ret   <= S_YSCL;
                end
                S_YSCL: begin
                    r_sa    <= u_val;
                    r_sb    <= VW'(r_height);
                    r_state <= S_WAIT;
                    r_ret   <= S_FIN;
                end
                S_FIN: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid <= 1'b1;
                        o_visible   <= r_vis;
                        o_screen_x  <= r_vis ? r_sx : '0;
                        o_screen_y  <= r_vis ? r_sres : '0;
                        o_depth_w   <= r_vw;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default:           r_width  <= r_width;
            endcase
        end
    end

    // Modelview (lower half) and projection (upper half) store.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_kind == KIND_LOAD_MV || i_kind == KIND_LOAD_PJ)) begin
            r_mp_mem[{i_kind[0], i_coef_index}] <= i_coef_value;
        end
        r_mpa <= r_mp_mem[mp_ra];
        r_mpb <= r_mp_mem[mp_rb];
    end

    // Combined store; an entry not yet written reads as the identity matrix.
    always_ff @(posedge i_clk) begin
        if (r_t2.vld && r_t2.last && r_t2.dst == DST_COMB) begin
            r_cb_mem[r_t2.addr] <= acc_sat;
        end
        r_cbq    <= r_cb_mem[cb_ra];
        r_cbv_q  <= r_cb_v[cb_ra];
        r_cbdiag <= (cb_ra[3:2] == cb_ra[1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cb_v <= '0;
        end else if (r_t2.vld && r_t2.last && r_t2.dst == DST_COMB) begin
            r_cb_v[r_t2.addr] <= 1'b1;
        end
    end

    // Operand selection and magnitude product.
    always_comb begin
        cb_val = r_cbv_q ? r_cbq : (r_cbdiag ? ONE_Q : '0);
        case (r_t1.src)
            SRC_MP:  a_op = r_mpa;
            SRC_CB:  a_op = cb_val;
            default: a_op = r_sa;
        endcase
        b_op = (r_t1.src == SRC_MP) ? r_mpb : r_sb;
        ma   = a_op[VW-1] ? -a_op : a_op;
        mb   = b_op[VW-1] ? -b_op : b_op;
    end

    // Rounding to nearest, ties away from zero, magnitude clamped at 2^60; unshifted products pass unrounded.
    always_comb begin
        prd_add = {1'b0, r_prod} + (PRD_W+1)'(HALF_Q);
        big     = BIG_W'(prd_add[PRD_W:FRAC_BITS]);
        if (!r_t2.shift)                       mag_q = CLP_W'(r_prod);
        else if (big > (BIG_W'(1) << 60))      mag_q = CLP_W'(BIG_W'(1) << 60);
        else                                   mag_q = CLP_W'(big);
        sp      = r_neg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
        acc_sum = (r_t2.first ? ACC_W'(0) : r_acc) + ACC_W'(sp);
        acc_sat = sat_acc(acc_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
        end else begin
            r_t1 <= iss;
            r_t2 <= r_t1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PRD_W'($unsigned(ma)) * PRD_W'($unsigned(mb));
        r_neg  <= a_op[VW-1] ^ b_op[VW-1];
        if (r_t2.vld) begin
            r_acc <= acc_sum;
            if (r_t2.last) begin
                case (r_t2.dst)
                    DST_VREG: begin
                        case (r_t2.addr[1:0])
                            2'd0:    r_vx <= acc_sat;
                            2'd1:    r_vy <= acc_sat;
                            2'd3:    r_vw <= acc_sat;
                            default: r_vx <= r_vx;
                        endcase
                    end
                    DST_SCAL: r_sres <= acc_sat;
                    default:  r_sres <= r_sres;
                endcase
            end
        end
    end

    `VSP_ASSERT_NOW(a_pipe_not_idle, r_t2.vld, r_state != S_IDLE, "pipeline busy while idle")
    `VSP_ASSERT_NOW(a_div_positive, r_state == S_DIV, r_vw > 0, "divider run with w not positive")
    `VSP_ASSERT_NOW(a_fin_drained, r_state == S_FIN, !pipe_busy, "result taken before pipeline drained")
    `VSP_ASSERT_NEXT(a_fin_out, r_state == S_FIN && (!o_out_valid || !i_out_stall), o_out_valid && r_state == S_IDLE, "result not presented")

endmodule
